// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression that must never be true, skipped while reset is high
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ----- hdl/bdfs_pkg.sv -----
// shared types and constants of the byte fifo with delimiter search
// no dependencies; used by every module of the block
package bdfs_pkg;

  // field widths
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int RUN_W    = 7;
  localparam int OFFSET_W = 12;
  localparam int FILL_W   = 13;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd0;
  localparam logic [OP_W-1:0] OP_READ       = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_UNTIL = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_PEEK
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic                found;
    logic [OFFSET_W-1:0] found_offset;
    logic                overflow;
    logic [FILL_W-1:0]   fill_level;
  } result_t;

endpackage

// ----- hdl/bdfs_ram.sv -----
// byte store: one write port, one read port with registered read data
// depends on bdfs_pkg for the byte width
module bdfs_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bdfs_pkg::BYTE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bdfs_pkg::BYTE_W-1:0] rdata
);

  logic [bdfs_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bdfs_ctrl.sv -----
// sequencer, pointers and the shared scan/compare unit of the byte fifo
// depends on bdfs_pkg; drives bdfs_ram and feeds bdfs_outreg
module bdfs_ctrl #(
  parameter int CAPACITY = 4096,
  parameter int MAX_RUN  = 64,
  parameter int PW       = 12,
  parameter int CW       = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdfs_pkg::OP_W-1:0]     op,
  input  logic [bdfs_pkg::BYTE_W-1:0]   data_byte,
  input  logic [bdfs_pkg::RUN_W-1:0]    max_count,
  input  logic [bdfs_pkg::BYTE_W-1:0]   delimiter,
  input  logic                          inclusive,
  input  logic                          out_free,
  output logic                          res_load,
  output bdfs_pkg::result_t             res,
  output logic                          mem_we,
  output logic [PW-1:0]                 mem_waddr,
  output logic [bdfs_pkg::BYTE_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [PW-1:0]                 mem_raddr,
  input  logic [bdfs_pkg::BYTE_W-1:0]   mem_rdata
);

  localparam int RW = bdfs_pkg::RUN_W;
  localparam int LW = (CW > RW) ? CW : RW;
  localparam logic [PW:0]   SUM_CAP = (PW+1)'(CAPACITY);
  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);
  localparam logic [RW-1:0] RUN_CAP = RW'(MAX_RUN);

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [PW:0] sum;
    sum = (PW+1)'(base) + (PW+1)'(ofs);
    if (sum >= SUM_CAP) begin
      sum = sum - SUM_CAP;
    end
    return sum[PW-1:0];
  endfunction

  bdfs_pkg::state_t state, state_next;

  logic [PW-1:0]                 rp;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 si;
  logic [CW-1:0]                 slim;
  logic                          cmp_v;
  logic [CW-1:0]                 cmp_idx;
  logic [bdfs_pkg::OP_W-1:0]     op_q;
  logic [bdfs_pkg::BYTE_W-1:0]   delim_q;
  logic                          incl_q;
  logic [RW-1:0]                 rem;
  logic [CW-1:0]                 fill_q;

  logic          accept;
  logic          full;
  logic [RW-1:0] m_lim;
  logic          cnt_lt_m;
  logic [RW-1:0] run_n;
  logic [CW-1:0] lim_cw;
  logic          scan_hit;
  logic          scan_done;
  logic          scan_issue;
  logic [RW-1:0] until_n;
  logic          emit_fire;
  logic [PW-1:0] rp_inc;

  assign in_ready   = (state == bdfs_pkg::ST_IDLE) && out_free;
  assign accept     = in_valid && in_ready;
  assign full       = (cnt >= CNT_CAP);
  assign m_lim      = (max_count > RUN_CAP) ? RUN_CAP : max_count;
  assign cnt_lt_m   = (LW'(cnt) < LW'(m_lim));
  assign run_n      = cnt_lt_m ? RW'(cnt) : m_lim;
  assign lim_cw     = cnt_lt_m ? cnt : CW'(m_lim);
  assign scan_hit   = cmp_v && (mem_rdata == delim_q);
  assign scan_done  = (state == bdfs_pkg::ST_SCAN) &&
                      (scan_hit || (!cmp_v && (si == slim)));
  assign scan_issue = (state == bdfs_pkg::ST_SCAN) && !scan_done && (si < slim);
  assign until_n    = scan_hit ? (RW'(cmp_idx) + RW'(incl_q)) : RW'(slim);
  assign emit_fire  = (state == bdfs_pkg::ST_READ) && out_free;
  assign rp_inc     = wrap_add(rp, CW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bdfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            bdfs_pkg::OP_READ:       state_next = (run_n != '0) ? bdfs_pkg::ST_READ
                                                                : bdfs_pkg::ST_IDLE;
            bdfs_pkg::OP_READ_UNTIL: state_next = bdfs_pkg::ST_SCAN;
            bdfs_pkg::OP_FIND:       state_next = bdfs_pkg::ST_SCAN;
            bdfs_pkg::OP_PEEK:       state_next = bdfs_pkg::ST_PEEK;
            default:                 state_next = bdfs_pkg::ST_IDLE;
          endcase
        end
      end
      bdfs_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (op_q == bdfs_pkg::OP_READ_UNTIL && until_n != '0) begin
            state_next = bdfs_pkg::ST_READ;
          end else begin
            state_next = bdfs_pkg::ST_IDLE;
          end
        end
      end
      bdfs_pkg::ST_READ: begin
        if (emit_fire && rem == RW'(1)) begin
          state_next = bdfs_pkg::ST_IDLE;
        end
      end
      bdfs_pkg::ST_PEEK: begin
        state_next = bdfs_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: memory requests and result loads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wrap_add(rp, cnt);
    mem_wdata = data_byte;
    mem_re    = 1'b0;
    mem_raddr = rp;
    res_load  = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    res.fill_level = bdfs_pkg::FILL_W'(cnt);
    unique case (state)
      bdfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            bdfs_pkg::OP_WRITE: begin
              mem_we         = !full;
              res_load       = 1'b1;
              res.overflow   = full;
              res.fill_level = full ? bdfs_pkg::FILL_W'(cnt)
                                    : bdfs_pkg::FILL_W'(CW'(cnt + 1'b1));
            end
            bdfs_pkg::OP_READ: begin
              if (run_n != '0) begin
                mem_re = 1'b1;
              end else begin
                res_load = 1'b1;
              end
            end
            bdfs_pkg::OP_READ_UNTIL, bdfs_pkg::OP_FIND: begin
            end
            bdfs_pkg::OP_PEEK: begin
              mem_re = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      bdfs_pkg::ST_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = wrap_add(rp, si);
        if (scan_done) begin
          if (op_q == bdfs_pkg::OP_FIND) begin
            res_load         = 1'b1;
            res.found        = scan_hit;
            res.found_offset = scan_hit ? bdfs_pkg::OFFSET_W'(cmp_idx) : '0;
          end else if (until_n == '0) begin
            res_load = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rp;
          end
        end
      end
      bdfs_pkg::ST_READ: begin
        if (out_free) begin
          res_load       = 1'b1;
          res.out_byte   = mem_rdata;
          res.byte_valid = 1'b1;
          res.last       = (rem == RW'(1));
          res.fill_level = bdfs_pkg::FILL_W'(fill_q);
          if (rem != RW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = rp_inc;
          end
        end
      end
      bdfs_pkg::ST_PEEK: begin
        res_load = 1'b1;
        if (cnt != '0) begin
          res.out_byte   = mem_rdata;
          res.byte_valid = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdfs_pkg::ST_IDLE;
      rp    <= '0;
      cnt   <= '0;
      cmp_v <= 1'b0;
    end else begin
      state <= state_next;
      cmp_v <= scan_issue;
      if (accept) begin
        if (op == bdfs_pkg::OP_WRITE && !full) begin
          cnt <= CW'(cnt + 1'b1);
        end
      end
      if (emit_fire) begin
        rp  <= (cnt == CW'(1)) ? '0 : rp_inc;
        cnt <= CW'(cnt - 1'b1);
      end
    end
  end

  // operand and sequencing registers
  always_ff @(posedge clk) begin
    cmp_idx <= si;
    if (accept) begin
      op_q    <= op;
      delim_q <= delimiter;
      incl_q  <= inclusive;
      si      <= '0;
      slim    <= (op == bdfs_pkg::OP_FIND) ? cnt : lim_cw;
      rem     <= run_n;
      fill_q  <= CW'(LW'(cnt) - LW'(run_n));
    end
    if (scan_issue) begin
      si <= CW'(si + 1'b1);
    end
    if (scan_done) begin
      rem    <= until_n;
      fill_q <= CW'(LW'(cnt) - LW'(until_n));
    end
    if (emit_fire) begin
      rem <= RW'(rem - 1'b1);
    end
  end

endmodule

// ----- hdl/bdfs_outreg.sv -----
// result register between the sequencer and the output channel
// depends on bdfs_pkg for the result structure
module bdfs_outreg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  bdfs_pkg::result_t             res,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdfs_pkg::BYTE_W-1:0]   out_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic                          found,
  output logic [bdfs_pkg::OFFSET_W-1:0] found_offset,
  output logic                          overflow,
  output logic [bdfs_pkg::FILL_W-1:0]   fill_level
);

  bdfs_pkg::result_t hold;

  assign free         = !out_valid || out_ready;
  assign out_byte     = hold.out_byte;
  assign byte_valid   = hold.byte_valid;
  assign last         = hold.last;
  assign found        = hold.found;
  assign found_offset = hold.found_offset;
  assign overflow     = hold.overflow;
  assign fill_level   = hold.fill_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

endmodule

// ----- hdl/byte_fifo_with_delimiter_search.sv -----
// Circular byte fifo with delimiter search. Each input transaction carries one
// operation: write a byte, read a run of up to max_count bytes (at most MAX_RUN),
// read as far as a delimiter byte, peek the oldest byte, or find the delimiter's
// offset from the oldest byte. Reads give one output transaction per byte removed
// (a single byte-free one if none is removed), with last on the final one; every
// other operation gives exactly one. fill_level on every output is the count after
// the whole operation. Writes stream back to back while their results are taken; a
// read run makes one memory read per byte, the next byte's address issued while the
// current one is handed out; a peek makes one memory read; a find walks the stored
// bytes through the single compare unit, one byte a cycle, up to the first match; a
// read-until first scans at most min(max_count, MAX_RUN, fill) bytes and then reads
// like a read run. These steps follow from the one-port-read byte memory. The
// byte store needs no clearing after reset; in_ready drops while an operation is
// in progress or a result is still waiting to be taken.
// depends on bdfs_pkg, bdfs_ram, bdfs_ctrl and bdfs_outreg
module byte_fifo_with_delimiter_search #(
  parameter int CAPACITY = 4096,
  parameter int MAX_RUN  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdfs_pkg::OP_W-1:0]     op,
  input  logic [bdfs_pkg::BYTE_W-1:0]   data_byte,
  input  logic [bdfs_pkg::RUN_W-1:0]    max_count,
  input  logic [bdfs_pkg::BYTE_W-1:0]   delimiter,
  input  logic                          inclusive,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdfs_pkg::BYTE_W-1:0]   out_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic                          found,
  output logic [bdfs_pkg::OFFSET_W-1:0] found_offset,
  output logic                          overflow,
  output logic [bdfs_pkg::FILL_W-1:0]   fill_level
);

  // pointer width and count width (count must reach CAPACITY itself)
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // memory request lines
  logic                        mem_we;
  logic [PW-1:0]               mem_waddr;
  logic [bdfs_pkg::BYTE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [PW-1:0]               mem_raddr;
  logic [bdfs_pkg::BYTE_W-1:0] mem_rdata;

  // result handoff to the output register
  logic              res_load;
  logic              out_free;
  bdfs_pkg::result_t res;

  // byte store, written at the tail, read at the head or scan position
  bdfs_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer with head pointer, fill count and the shared compare unit
  bdfs_ctrl #(
    .CAPACITY (CAPACITY),
    .MAX_RUN  (MAX_RUN),
    .PW       (PW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .data_byte (data_byte),
    .max_count (max_count),
    .delimiter (delimiter),
    .inclusive (inclusive),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: a new result loads in the cycle the old one is taken
  bdfs_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         (res_load),
    .res          (res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .found        (found),
    .found_offset (found_offset),
    .overflow     (overflow),
    .fill_level   (fill_level)
  );

endmodule

// ----- hdl/bdfs_chk.sv -----
// port-level checker for the byte fifo, bound to the top level
// depends on bdfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module bdfs_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [bdfs_pkg::OP_W-1:0]     op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdfs_pkg::BYTE_W-1:0]   out_byte,
  input logic                          byte_valid,
  input logic                          last,
  input logic                          found,
  input logic [bdfs_pkg::OFFSET_W-1:0] found_offset,
  input logic                          overflow,
  input logic [bdfs_pkg::FILL_W-1:0]   fill_level
);

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last) && $stable(fill_level) && $stable(found_offset))

  // find and overflow results are single, byte-free transactions
  `ASSERT_NEVER(a_flag_single, clk, rst, out_valid && (found || overflow) && (!last || byte_valid))

  // only multi-byte reads produce non-final results, and those carry bytes
  `ASSERT_NEVER(a_mid_byte, clk, rst, out_valid && !last && !byte_valid)

  // a peek needs a memory read, so the next cycle cannot take input
  `ASSERT_CLK(a_peek_busy, clk, rst, in_valid && in_ready && op == bdfs_pkg::OP_PEEK |=> !in_ready)

endmodule

bind byte_fifo_with_delimiter_search bdfs_chk u_chk (.*);
